// File: rtl/ldpc_pkg.sv
// ----------------------------------------------------------------------------
// ldpc_pkg
// Shared types and constants of the lens distortion point correction core.
// ----------------------------------------------------------------------------
package ldpc_pkg;

  typedef struct packed {
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] corrected_x;
    logic signed [31:0] corrected_y;
    logic               clipped;
  } out_beat_t;

  typedef struct packed {
    logic        [23:0] focal_x;
    logic        [23:0] focal_y;
    logic        [23:0] center_x;
    logic        [23:0] center_y;
    logic signed [31:0] radial_k1;
    logic signed [31:0] radial_k2;
    logic signed [31:0] tangential_p1;
    logic signed [31:0] tangential_p2;
  } cfg_t;

  typedef enum logic [2:0] {
    REG_FOCAL_X       = 3'd0,
    REG_FOCAL_Y       = 3'd1,
    REG_CENTER_X      = 3'd2,
    REG_CENTER_Y      = 3'd3,
    REG_RADIAL_K1     = 3'd4,
    REG_RADIAL_K2     = 3'd5,
    REG_TANGENTIAL_P1 = 3'd6,
    REG_TANGENTIAL_P2 = 3'd7
  } reg_idx_e;

  // third radial coefficient, signed q4.28
  localparam logic signed [31:0] RADIAL_K3 = 32'sd0;

  localparam logic [23:0] FOCAL_RESET = 24'd256;

  // divider: quotient bits and bits resolved per stage
  localparam int DIV_QBITS = 32;
  localparam int DIV_STEP  = 2;
  localparam int DIV_STAGES = DIV_QBITS / DIV_STEP;

  localparam logic signed [31:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] SAT_MIN = 32'sh80000000;

endpackage

// File: rtl/ldpc_div.sv
// ----------------------------------------------------------------------------
// ldpc_div
// Pipelined normalizer: (point - center) * 2^30 / focal for both axes,
// truncated toward zero and saturated to signed q2.30.
// ----------------------------------------------------------------------------
module ldpc_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ldpc_pkg::in_beat_t   beat_i,
  input  ldpc_pkg::cfg_t       cfg_i,
  output logic                 valid_o,
  output ldpc_pkg::in_beat_t   beat_o,
  output logic signed [31:0]   x_o,
  output logic signed [31:0]   y_o
);

  localparam int NS = ldpc_pkg::DIV_STAGES;
  localparam int ST = ldpc_pkg::DIV_STEP;

  logic [NS:0]        vld_q;
  ldpc_pkg::in_beat_t pt_q  [NS+1];
  logic [23:0]        rem_q [NS+1][2];
  logic [31:0]        quo_q [NS+1][2];
  logic               neg_q [NS+1][2];
  logic               ovf_q [NS+1][2];
  logic [1:0]         nb_q  [2];

  logic [23:0]        rem_d [NS][2];
  logic [31:0]        quo_d [NS][2];

  logic [23:0]        fd [2];
  logic [23:0]        rem0_d [2];
  logic [1:0]         nb0_d [2];
  logic               neg0_d [2];
  logic               ovf0_d [2];
  logic signed [31:0] res [2];

  // zero focal length reads as one lsb
  assign fd[0] = (cfg_i.focal_x == '0) ? 24'd1 : cfg_i.focal_x;
  assign fd[1] = (cfg_i.focal_y == '0) ? 24'd1 : cfg_i.focal_y;

  always_comb begin
    logic signed [25:0] d;
    logic        [25:0] mag;
    logic signed [23:0] p;
    logic        [23:0] c;
    for (int l = 0; l < 2; l++) begin
      p = (l == 0) ? beat_i.point_x : beat_i.point_y;
      c = (l == 0) ? cfg_i.center_x : cfg_i.center_y;
      d = $signed({{2{p[23]}}, p}) - $signed({2'b00, c});
      mag = d[25] ? 26'(-d) : 26'(d);
      neg0_d[l] = d[25];
      ovf0_d[l] = (mag >= {fd[l], 2'b00});
      rem0_d[l] = mag[25:2];
      nb0_d[l]  = mag[1:0];
    end
  end

  // restoring division, ST quotient bits per stage
  always_comb begin
    logic [24:0] t;
    logic [23:0] r;
    logic [31:0] qv;
    logic        b;
    for (int s = 0; s < NS; s++) begin
      for (int l = 0; l < 2; l++) begin
        r  = rem_q[s][l];
        qv = quo_q[s][l];
        for (int k = 0; k < ST; k++) begin
          if (s * ST + k == 0) begin
            b = nb_q[l][1];
          end else if (s * ST + k == 1) begin
            b = nb_q[l][0];
          end else begin
            b = 1'b0;
          end
          t = {r, b};
          if (t >= {1'b0, fd[l]}) begin
            t  = t - {1'b0, fd[l]};
            qv = {qv[30:0], 1'b1};
          end else begin
            qv = {qv[30:0], 1'b0};
          end
          r = t[23:0];
        end
        rem_d[s][l] = r;
        quo_d[s][l] = qv;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt_q[0] <= beat_i;
      for (int l = 0; l < 2; l++) begin
        rem_q[0][l] <= rem0_d[l];
        quo_q[0][l] <= '0;
        neg_q[0][l] <= neg0_d[l];
        ovf_q[0][l] <= ovf0_d[l];
        nb_q[l]     <= nb0_d[l];
      end
      for (int s = 0; s < NS; s++) begin
        pt_q[s+1] <= pt_q[s];
        for (int l = 0; l < 2; l++) begin
          rem_q[s+1][l] <= rem_d[s][l];
          quo_q[s+1][l] <= quo_d[s][l];
          neg_q[s+1][l] <= neg_q[s][l];
          ovf_q[s+1][l] <= ovf_q[s][l];
        end
      end
    end
  end

  // sign and saturation
  always_comb begin
    logic [31:0] m;
    for (int l = 0; l < 2; l++) begin
      m = quo_q[NS][l];
      if (ovf_q[NS][l]) begin
        res[l] = neg_q[NS][l] ? ldpc_pkg::SAT_MIN : ldpc_pkg::SAT_MAX;
      end else if (neg_q[NS][l]) begin
        res[l] = (m > 32'h80000000) ? ldpc_pkg::SAT_MIN : $signed(~m + 32'd1);
      end else begin
        res[l] = (m > 32'h7fffffff) ? ldpc_pkg::SAT_MAX : $signed(m);
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign beat_o  = pt_q[NS];
  assign x_o     = res[0];
  assign y_o     = res[1];

endmodule

// File: rtl/ldpc_poly.sv
// ----------------------------------------------------------------------------
// ldpc_poly
// Distortion pipeline: radial and tangential terms, reprojection,
// reflection and output saturation. Last stage is the output register.
// ----------------------------------------------------------------------------
module ldpc_poly (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ldpc_pkg::in_beat_t   beat_i,
  input  logic signed [31:0]   x_i,
  input  logic signed [31:0]   y_i,
  input  ldpc_pkg::cfg_t       cfg_i,
  output logic                 valid_o,
  output ldpc_pkg::out_beat_t  beat_o
);

  localparam int NSTG = 11;

  logic [NSTG-1:0]     vld_q;
  ldpc_pkg::in_beat_t  pt_q [NSTG-1];
  logic signed [31:0]  xc_q [7][2];
  logic signed [38:0]  ts_q [5][2];

  logic signed [31:0]  sq1_q [2];
  logic signed [31:0]  xy1_q;
  logic signed [32:0]  r2_2_q, xy2_2_q;
  logic signed [33:0]  sb2_q [2];
  logic signed [32:0]  r2_3_q;
  logic signed [37:0]  r4_3_q;
  logic signed [36:0]  k1r2_3_q;
  logic signed [36:0]  ta3_q [2];
  logic signed [37:0]  tb3_q [2];
  logic signed [57:0]  p6lo_q;
  logic signed [46:0]  p6hi_q;
  logic signed [56:0]  kklo_q;
  logic signed [45:0]  kkhi_q;
  logic signed [36:0]  k1r2_4_q;
  logic signed [42:0]  r6_q, rs5_q, rs6_q;
  logic signed [56:0]  k3lo_q;
  logic signed [50:0]  k3hi_q;
  logic signed [47:0]  rad_q;
  logic signed [56:0]  xrlo_q [2];
  logic signed [55:0]  xrhi_q [2];
  logic signed [52:0]  dx_q [2];
  logic signed [49:0]  pflo_q [2];
  logic signed [53:0]  pfhi_q [2];
  ldpc_pkg::out_beat_t out_q;

  logic signed [31:0]  sq1_d [2];
  logic signed [31:0]  xy1_d;
  logic signed [32:0]  r2_2_d, xy2_2_d;
  logic signed [33:0]  sb2_d [2];
  logic signed [37:0]  r4_3_d;
  logic signed [36:0]  k1r2_3_d;
  logic signed [36:0]  ta3_d [2];
  logic signed [37:0]  tb3_d [2];
  logic signed [38:0]  ts4_d [2];
  logic signed [57:0]  p6lo_d;
  logic signed [46:0]  p6hi_d;
  logic signed [56:0]  kklo_d;
  logic signed [45:0]  kkhi_d;
  logic signed [42:0]  r6_d, rs5_d;
  logic signed [56:0]  k3lo_d;
  logic signed [50:0]  k3hi_d;
  logic signed [47:0]  rad_d;
  logic signed [56:0]  xrlo_d [2];
  logic signed [55:0]  xrhi_d [2];
  logic signed [52:0]  dx_d [2];
  logic signed [49:0]  pflo_d [2];
  logic signed [53:0]  pfhi_d [2];
  ldpc_pkg::out_beat_t out_d;

  logic signed [31:0]  pa [2];
  logic signed [31:0]  pb [2];
  logic signed [24:0]  fs [2];
  logic signed [24:0]  cs [2];

  assign pa[0] = cfg_i.tangential_p1;
  assign pa[1] = cfg_i.tangential_p2;
  assign pb[0] = cfg_i.tangential_p2;
  assign pb[1] = cfg_i.tangential_p1;
  assign fs[0] = $signed({1'b0, cfg_i.focal_x});
  assign fs[1] = $signed({1'b0, cfg_i.focal_y});
  assign cs[0] = $signed({1'b0, cfg_i.center_x});
  assign cs[1] = $signed({1'b0, cfg_i.center_y});

  always_comb begin
    logic signed [63:0] m64;
    logic signed [65:0] m66;
    logic signed [64:0] m65;
    logic signed [70:0] f71;
    logic signed [69:0] f70;
    logic signed [74:0] f75;
    logic signed [79:0] f80;
    logic signed [77:0] f78;
    logic signed [48:0] proj;
    logic signed [50:0] corr;
    logic signed [23:0] p;
    logic signed [31:0] xin [2];
    logic signed [31:0] cv [2];
    logic               clip;
    xin[0] = x_i;
    xin[1] = y_i;
    clip   = 1'b0;
    // stage 1: squares and cross term
    for (int l = 0; l < 2; l++) begin
      m64 = xin[l] * xin[l];
      sq1_d[l] = m64[63:32];
    end
    m64   = x_i * y_i;
    xy1_d = m64[63:32];
    // stage 2: r2 and tangential operands
    r2_2_d  = 33'(sq1_q[0]) + 33'(sq1_q[1]);
    xy2_2_d = 33'(xy1_q) <<< 1;
    for (int l = 0; l < 2; l++) begin
      sb2_d[l] = 34'(r2_2_d) + (34'(sq1_q[l]) <<< 1);
    end
    // stage 3: r4, k1 term, tangential products
    m66      = r2_2_q * r2_2_q;
    r4_3_d   = m66[65:28];
    m65      = cfg_i.radial_k1 * r2_2_q;
    k1r2_3_d = m65[64:28];
    for (int l = 0; l < 2; l++) begin
      m65      = pa[l] * xy2_2_q;
      ta3_d[l] = m65[64:28];
      m66      = pb[l] * sb2_q[l];
      tb3_d[l] = m66[65:28];
    end
    // stage 4: r6 and k2 partial products, tangential sums
    p6lo_d = r2_3_q * $signed({1'b0, r4_3_q[23:0]});
    p6hi_d = r2_3_q * $signed(r4_3_q[37:24]);
    kklo_d = cfg_i.radial_k2 * $signed({1'b0, r4_3_q[23:0]});
    kkhi_d = cfg_i.radial_k2 * $signed(r4_3_q[37:24]);
    for (int l = 0; l < 2; l++) begin
      ts4_d[l] = 39'(ta3_q[l]) + 39'(tb3_q[l]);
    end
    // stage 5: combine r6 and k2 term
    f71   = (71'(p6hi_q) <<< 24) + 71'(p6lo_q);
    r6_d  = f71[70:28];
    f70   = (70'(kkhi_q) <<< 24) + 70'(kklo_q);
    rs5_d = 43'sd268435456 + 43'(k1r2_4_q) + 43'($signed(f70[69:28]));
    // stage 6: k3 partial products
    k3lo_d = ldpc_pkg::RADIAL_K3 * $signed({1'b0, r6_q[23:0]});
    k3hi_d = ldpc_pkg::RADIAL_K3 * $signed(r6_q[42:24]);
    // stage 7: radial factor
    f75   = (75'(k3hi_q) <<< 24) + 75'(k3lo_q);
    rad_d = 48'(rs6_q) + 48'($signed(f75[74:28]));
    // stage 8: coordinate times radial factor, partial products
    for (int l = 0; l < 2; l++) begin
      xrlo_d[l] = xc_q[6][l] * $signed({1'b0, rad_q[23:0]});
      xrhi_d[l] = xc_q[6][l] * $signed(rad_q[47:24]);
    end
    // stage 9: distorted coordinate
    for (int l = 0; l < 2; l++) begin
      f80     = (80'(xrhi_q[l]) <<< 24) + 80'(xrlo_q[l]);
      dx_d[l] = 53'($signed(f80[79:28])) + (53'(ts_q[4][l]) <<< 2);
    end
    // stage 10: focal scaling, partial products
    for (int l = 0; l < 2; l++) begin
      pflo_d[l] = fs[l] * $signed({1'b0, dx_q[l][23:0]});
      pfhi_d[l] = fs[l] * $signed(dx_q[l][52:24]);
    end
    // stage 11: reproject, reflect, saturate
    for (int l = 0; l < 2; l++) begin
      f78  = (78'(pfhi_q[l]) <<< 24) + 78'(pflo_q[l]);
      proj = 49'($signed(f78[77:30])) + 49'(cs[l]);
      p    = (l == 0) ? pt_q[9].point_x : pt_q[9].point_y;
      corr = (51'(proj) <<< 1) - 51'(p);
      if (corr > 51'(ldpc_pkg::SAT_MAX)) begin
        cv[l] = ldpc_pkg::SAT_MAX;
        clip  = 1'b1;
      end else if (corr < 51'(ldpc_pkg::SAT_MIN)) begin
        cv[l] = ldpc_pkg::SAT_MIN;
        clip  = 1'b1;
      end else begin
        cv[l] = corr[31:0];
      end
    end
    out_d.corrected_x = cv[0];
    out_d.corrected_y = cv[1];
    out_d.clipped     = clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pt_q[0] <= beat_i;
      for (int s = 1; s < NSTG - 1; s++) begin
        pt_q[s] <= pt_q[s-1];
      end
      xc_q[0][0] <= x_i;
      xc_q[0][1] <= y_i;
      for (int s = 1; s < 7; s++) begin
        xc_q[s] <= xc_q[s-1];
      end
      ts_q[0] <= ts4_d;
      for (int s = 1; s < 5; s++) begin
        ts_q[s] <= ts_q[s-1];
      end
      sq1_q    <= sq1_d;
      xy1_q    <= xy1_d;
      r2_2_q   <= r2_2_d;
      xy2_2_q  <= xy2_2_d;
      sb2_q    <= sb2_d;
      r2_3_q   <= r2_2_q;
      r4_3_q   <= r4_3_d;
      k1r2_3_q <= k1r2_3_d;
      ta3_q    <= ta3_d;
      tb3_q    <= tb3_d;
      p6lo_q   <= p6lo_d;
      p6hi_q   <= p6hi_d;
      kklo_q   <= kklo_d;
      kkhi_q   <= kkhi_d;
      k1r2_4_q <= k1r2_3_q;
      r6_q     <= r6_d;
      rs5_q    <= rs5_d;
      k3lo_q   <= k3lo_d;
      k3hi_q   <= k3hi_d;
      rs6_q    <= rs5_q;
      rad_q    <= rad_d;
      xrlo_q   <= xrlo_d;
      xrhi_q   <= xrhi_d;
      dx_q     <= dx_d;
      pflo_q   <= pflo_d;
      pfhi_q   <= pfhi_d;
      out_q    <= out_d;
    end
  end

  assign valid_o = vld_q[NSTG-1];
  assign beat_o  = out_q;

endmodule

// File: rtl/lens_distortion_point_correction_core.sv
// ----------------------------------------------------------------------------
// lens_distortion_point_correction_core
// Brown-Conrady lens distortion applied to a stream of image points.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid_i / in_ready_o carry one point beat (q16.8 pixels)
//   out channel : out_valid_o / out_ready_i carry one corrected beat per point
//   cfg channel : cfg_valid_i / cfg_ready_o write register cfg_index_i with
//                 cfg_data_i; cfg_ready_o is always high. Write only while
//                 no point is in flight.
// The normalizing divider (two quotient bits per stage) feeds the
// distortion and reprojection pipeline, whose last stage is the output
// register. Throughput is one point per cycle while out_ready_i is high.
// When the receiver stalls with a beat waiting, the whole pipeline holds
// and in_ready_o drops; bubbles do not stall it.
// Reset clears all pipeline valid bits and sets the focal lengths to 1.0
// and the center and distortion coefficients to 0.
// ----------------------------------------------------------------------------
module lens_distortion_point_correction_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ldpc_pkg::in_beat_t  in_beat_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ldpc_pkg::out_beat_t out_beat_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i
);

  ldpc_pkg::cfg_t     cfg_q;
  logic               en;
  logic               div_valid;
  ldpc_pkg::in_beat_t div_beat;
  logic signed [31:0] div_x, div_y;

  assign cfg_ready_o = 1'b1;
  assign en          = !out_valid_o || out_ready_i;
  assign in_ready_o  = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.focal_x       <= ldpc_pkg::FOCAL_RESET;
      cfg_q.focal_y       <= ldpc_pkg::FOCAL_RESET;
      cfg_q.center_x      <= '0;
      cfg_q.center_y      <= '0;
      cfg_q.radial_k1     <= '0;
      cfg_q.radial_k2     <= '0;
      cfg_q.tangential_p1 <= '0;
      cfg_q.tangential_p2 <= '0;
    end else if (cfg_valid_i) begin
      unique case (ldpc_pkg::reg_idx_e'(cfg_index_i))
        ldpc_pkg::REG_FOCAL_X:       cfg_q.focal_x       <= cfg_data_i[23:0];
        ldpc_pkg::REG_FOCAL_Y:       cfg_q.focal_y       <= cfg_data_i[23:0];
        ldpc_pkg::REG_CENTER_X:      cfg_q.center_x      <= cfg_data_i[23:0];
        ldpc_pkg::REG_CENTER_Y:      cfg_q.center_y      <= cfg_data_i[23:0];
        ldpc_pkg::REG_RADIAL_K1:     cfg_q.radial_k1     <= $signed(cfg_data_i);
        ldpc_pkg::REG_RADIAL_K2:     cfg_q.radial_k2     <= $signed(cfg_data_i);
        ldpc_pkg::REG_TANGENTIAL_P1: cfg_q.tangential_p1 <= $signed(cfg_data_i);
        ldpc_pkg::REG_TANGENTIAL_P2: cfg_q.tangential_p2 <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  ldpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .beat_i  (in_beat_i),
    .cfg_i   (cfg_q),
    .valid_o (div_valid),
    .beat_o  (div_beat),
    .x_o     (div_x),
    .y_o     (div_y)
  );

  ldpc_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .beat_i  (div_beat),
    .x_i     (div_x),
    .y_i     (div_y),
    .cfg_i   (cfg_q),
    .valid_o (out_valid_o),
    .beat_o  (out_beat_o)
  );

endmodule

// File: verif/lens_distortion_point_correction_checker.sv
// ----------------------------------------------------------------------------
// lens_distortion_point_correction_checker
// Watches the point, result and register channels of the core, predicts
// each corrected point from its own copy of the registers and compares
// every result beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module lens_distortion_point_correction_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  ldpc_pkg::in_beat_t  in_beat_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  ldpc_pkg::out_beat_t out_beat_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [2:0]          cfg_index_i,
  input  logic [31:0]         cfg_data_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  ldpc_pkg::cfg_t      regs;
  ldpc_pkg::out_beat_t corrected_q[$];
  int                  fails;

  assign fail_count_o = fails;
  assign pending_o    = corrected_q.size();

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // exact floor(a*b / 2^s), split to stay within 64 bits
  function automatic longint mul_shift(longint a, longint b, int s);
    longint lo_part;
    longint hi_part;
    lo_part = b & 64'hFFFFFF;
    hi_part = (b - lo_part) / 16777216;
    return floor_shift(a * hi_part + floor_shift(a * lo_part, 24), s - 24);
  endfunction

  function automatic longint normalize(longint p, longint c, longint f);
    longint q;
    q = ((p - c) * 1073741824) / ((f == 0) ? 1 : f);
    if (q > S32_MAX) q = S32_MAX;
    if (q < S32_MIN) q = S32_MIN;
    return q;
  endfunction

  function automatic logic signed [31:0] reflect(longint proj, longint p, ref logic clip);
    longint r;
    r = 2 * proj - p;
    if (r > S32_MAX) begin
      r = S32_MAX;
      clip = 1'b1;
    end else if (r < S32_MIN) begin
      r = S32_MIN;
      clip = 1'b1;
    end
    return r[31:0];
  endfunction

  function automatic ldpc_pkg::out_beat_t correct_point(ldpc_pkg::in_beat_t pt,
                                                        ldpc_pkg::cfg_t c);
    longint px, py, x, y, xx, yy, xy, r2, r4, r6, rad, tx, ty, dx, dy;
    longint k1, k2, k3, p1, p2, fx, fy;
    logic                clip;
    ldpc_pkg::out_beat_t res;
    px = pt.point_x;
    py = pt.point_y;
    k1 = c.radial_k1;
    k2 = c.radial_k2;
    k3 = ldpc_pkg::RADIAL_K3;
    p1 = c.tangential_p1;
    p2 = c.tangential_p2;
    fx = longint'(c.focal_x);
    fy = longint'(c.focal_y);
    x  = normalize(px, longint'(c.center_x), fx);
    y  = normalize(py, longint'(c.center_y), fy);
    xx = mul_shift(x, x, 32);
    yy = mul_shift(y, y, 32);
    xy = mul_shift(x, y, 32);
    r2 = xx + yy;
    r4 = mul_shift(r2, r2, 28);
    r6 = mul_shift(r2, r4, 28);
    rad = 268435456 + mul_shift(k1, r2, 28) + mul_shift(k2, r4, 28) + mul_shift(k3, r6, 28);
    tx = mul_shift(p1, 2 * xy, 28) + mul_shift(p2, r2 + 2 * xx, 28);
    ty = mul_shift(p2, 2 * xy, 28) + mul_shift(p1, r2 + 2 * yy, 28);
    dx = mul_shift(x, rad, 28) + 4 * tx;
    dy = mul_shift(y, rad, 28) + 4 * ty;
    clip = 1'b0;
    res.corrected_x = reflect(mul_shift(fx, dx, 30) + longint'(c.center_x), px, clip);
    res.corrected_y = reflect(mul_shift(fy, dy, 30) + longint'(c.center_y), py, clip);
    res.clipped = clip;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ldpc_pkg::out_beat_t want;
    if (!rst_ni) begin
      regs <= '{focal_x: ldpc_pkg::FOCAL_RESET, focal_y: ldpc_pkg::FOCAL_RESET,
                center_x: '0, center_y: '0, radial_k1: '0, radial_k2: '0,
                tangential_p1: '0, tangential_p2: '0};
      corrected_q.delete();
      fails <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (ldpc_pkg::reg_idx_e'(cfg_index_i))
          ldpc_pkg::REG_FOCAL_X:       regs.focal_x <= cfg_data_i[23:0];
          ldpc_pkg::REG_FOCAL_Y:       regs.focal_y <= cfg_data_i[23:0];
          ldpc_pkg::REG_CENTER_X:      regs.center_x <= cfg_data_i[23:0];
          ldpc_pkg::REG_CENTER_Y:      regs.center_y <= cfg_data_i[23:0];
          ldpc_pkg::REG_RADIAL_K1:     regs.radial_k1 <= cfg_data_i;
          ldpc_pkg::REG_RADIAL_K2:     regs.radial_k2 <= cfg_data_i;
          ldpc_pkg::REG_TANGENTIAL_P1: regs.tangential_p1 <= cfg_data_i;
          ldpc_pkg::REG_TANGENTIAL_P2: regs.tangential_p2 <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        corrected_q = {corrected_q, correct_point(in_beat_i, regs)};
      end
      if (out_valid_i && out_ready_i) begin
        if (corrected_q.size() == 0) begin
          if (fails < 10) $display("unexpected beat: %p", out_beat_i);
          fails <= fails + 1;
        end else begin
          want = corrected_q.pop_front();
          if (want !== out_beat_i) begin
            if (fails < 10) $display("mismatch: expected %p actual %p", want, out_beat_i);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

// File: verif/lens_distortion_point_correction_core_test.sv
// ----------------------------------------------------------------------------
// lens_distortion_point_correction_core_test
// Drives points and register writes into the core under several register
// settings, idle and stall patterns; the checker predicts and compares the results.
// ----------------------------------------------------------------------------
module lens_distortion_point_correction_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  ldpc_pkg::in_beat_t  in_beat = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ldpc_pkg::out_beat_t out_beat;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [2:0]          cfg_index = '0;
  logic [31:0]         cfg_data = '0;
  int                  fail_count;
  int                  pending;
  int                  idle_pct = 0;
  int                  stall_pct = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  lens_distortion_point_correction_core DUT (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_beat_i(in_beat),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_beat_o(out_beat),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  lens_distortion_point_correction_checker checker_u (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_beat_i(in_beat),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_beat_i(out_beat),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_point(logic signed [23:0] px, logic signed [23:0] py);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat <= '{point_x: px, point_y: py};
    do @(posedge clk_i); while (!in_ready);
  endtask

  task automatic write_reg(ldpc_pkg::reg_idx_e idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic drain_points();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // small focal lengths make far points and wide results common
  task automatic load_setting(int kind);
    logic [23:0] fx, fy;
    unique case (kind)
      0: begin fx = 24'd0; fy = 24'hFFFFFF; end
      1: begin fx = 24'hFFFFFF; fy = 24'd256; end
      default: begin
        fx = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(256, 262144));
        fy = ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(256, 262144));
      end
    endcase
    write_reg(ldpc_pkg::REG_FOCAL_X, {8'(0), fx});
    write_reg(ldpc_pkg::REG_FOCAL_Y, {8'(0), fy});
    write_reg(ldpc_pkg::REG_CENTER_X, (kind == 0) ? 32'hFFFFFF : $urandom_range(0, 524288));
    write_reg(ldpc_pkg::REG_CENTER_Y, (kind == 1) ? 32'hFFFFFF : $urandom);
    write_reg(ldpc_pkg::REG_RADIAL_K1, (kind == 0) ? 32'h80000000 : $urandom);
    write_reg(ldpc_pkg::REG_RADIAL_K2,
              (kind == 1) ? 32'h7FFFFFFF : $urandom >>> $urandom_range(31));
    write_reg(ldpc_pkg::REG_TANGENTIAL_P1, (kind == 1) ? 32'h80000000 : $urandom);
    write_reg(ldpc_pkg::REG_TANGENTIAL_P2,
              (kind == 0) ? 32'h7FFFFFFF : $urandom >>> $urandom_range(31));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    #100000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic signed [23:0] edges [5];
    edges = '{24'sh800000, 24'sh7FFFFF, 24'sh0, 24'shFFFFFF, 24'sh000100};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (edges[i]) send_point(edges[i], edges[4 - i]);
    drain_points();
    for (int ph = 0; ph < 12; ph++) begin
      load_setting(ph);
      unique case (ph % 4)
        0: begin idle_pct = 0; stall_pct = 0; end
        1: begin idle_pct = 62; stall_pct = 0; end
        2: begin idle_pct = 0; stall_pct = 62; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      if (ph < 2) begin
        foreach (edges[i]) send_point(edges[i], edges[(i + 2) % 5]);
      end
      for (int n = 0; n < 120; n++) begin
        if ($urandom_range(3) == 0) begin
          send_point(24'($urandom), 24'($urandom));
        end else begin
          send_point(24'($urandom_range(0, 200000)), 24'($urandom_range(0, 200000)));
        end
      end
      drain_points();
    end
    write_reg(ldpc_pkg::REG_FOCAL_X, 32'd256);
    cfg_valid <= 1'b0;
    send_point(24'sh7FFFFF, 24'sh800000);
    drain_points();
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: filelist.f
rtl/ldpc_pkg.sv
rtl/ldpc_div.sv
rtl/ldpc_poly.sv
rtl/lens_distortion_point_correction_core.sv
verif/lens_distortion_point_correction_checker.sv
verif/lens_distortion_point_correction_core_test.sv
